/* rtl/plbc_pkg.sv */
// shared types, constants and codes of the panel level blink classifier
package plbc_pkg;

  // bin ring geometry and field widths
  localparam int BINS     = 64;
  localparam int BIN_AW   = $clog2(BINS);
  localparam int C_W      = BIN_AW + 1;
  localparam int MIN_BINS = 16;
  localparam int CNT_W    = 16;
  localparam int LVL_W    = 12;
  localparam int LIM_W    = 7;
  localparam int SUM_W    = LVL_W + CNT_W;
  localparam int TOT_W    = CNT_W + BIN_AW;
  localparam int MEAN_W   = 16;
  localparam int Q_W      = 15;
  localparam int BIN_W    = 3 * CNT_W + SUM_W;

  // serial divider geometry
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 28;
  localparam int DIV_QW = 16;

  // fixed point constants
  localparam int Q_ONE       = 25600;
  localparam int SWING_RANGE = 1600;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register reset values
  localparam logic [LVL_W-1:0] RST_LOW_LEVEL   = 12'd100;
  localparam logic [LVL_W-1:0] RST_HIGH_LEVEL  = 12'd3995;
  localparam logic [LVL_W-1:0] RST_MID_FLOOR   = 12'd1500;
  localparam logic [LVL_W-1:0] RST_MID_CEILING = 12'd2500;
  localparam logic [LIM_W-1:0] RST_LARGE_LIM   = 7'd65;
  localparam logic [LIM_W-1:0] RST_SMALL_LIM   = 7'd55;
  localparam logic [LIM_W-1:0] RST_BLINK_LIM   = 7'd60;
  localparam logic [LVL_W-1:0] RST_MIN_SWING   = 12'd150;

  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_TICK   = 2'd1,
    FN_EVAL   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    BKT_LOW   = 2'd0,
    BKT_HIGH  = 2'd1,
    BKT_MID   = 2'd2,
    BKT_OTHER = 2'd3
  } bucket_e;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_STANDBY = 2'd1,
    CLS_LARGE   = 2'd2,
    CLS_SMALL   = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    CFG_LOW_LEVEL   = 3'd0,
    CFG_HIGH_LEVEL  = 3'd1,
    CFG_MID_FLOOR   = 3'd2,
    CFG_MID_CEILING = 3'd3,
    CFG_LARGE_LIM   = 3'd4,
    CFG_SMALL_LIM   = 3'd5,
    CFG_BLINK_LIM   = 3'd6,
    CFG_MIN_SWING   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [LVL_W-1:0] p1_level;
    logic [LVL_W-1:0] p2_level;
    logic [LVL_W-1:0] p3_level;
    logic [LVL_W-1:0] p4_level;
    logic [LVL_W-1:0] p5_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]     sig_p1;
    logic [1:0]     sig_p2;
    logic [1:0]     sig_p3;
    logic [1:0]     sig_p4;
    logic [1:0]     sig_p5;
    logic [1:0]     panel_class;
    logic [Q_W-1:0] large_pct;
    logic [Q_W-1:0] small_pct;
    logic [Q_W-1:0] blink_score;
    logic [Q_W-1:0] confidence;
  } out_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] low_level;
    logic [LVL_W-1:0] high_level;
    logic [LVL_W-1:0] mid_floor;
    logic [LVL_W-1:0] mid_ceiling;
    logic [LIM_W-1:0] large_pct_limit;
    logic [LIM_W-1:0] small_pct_limit;
    logic [LIM_W-1:0] blink_limit;
    logic [LVL_W-1:0] min_swing;
  } cfg_t;

  // one classified word waiting for the back end; sig[0] is pin 1
  typedef struct packed {
    logic [1:0]       func;
    logic [4:0][1:0]  sig;
    logic [LVL_W-1:0] p1_level;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] samples;
    logic [CNT_W-1:0] large_hits;
    logic [CNT_W-1:0] small_hits;
    logic [SUM_W-1:0] p1_sum;
  } bin_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/plbc_ram.sv */
// generic single write port ram with registered read
module plbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/plbc_div.sv */
// restoring serial divider, one quotient bit per cycle
module plbc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plbc_pkg::div_req_t  req_i,
  output plbc_pkg::div_rsp_t  rsp_o
);
  import plbc_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_QW + 1);

  logic                busy_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [DIV_DW-1:0]   rem_q;
  logic [DIV_DW-1:0]   den_q;
  logic [DIV_QW-1:0]   nlo_q;
  logic [DIV_QW-1:0]   quo_q;
  logic [DIV_DW:0]     trial;
  logic [DIV_DW:0]     diff;
  logic                ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, nlo_q[DIV_QW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (!busy_q) begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DIV_QW);
      end
    end else begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath; the top quotient bits of the numerator are known zero
  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        rem_q <= req_i.num[DIV_NW-1:DIV_QW];
        nlo_q <= req_i.num[DIV_QW-1:0];
        den_q <= req_i.den;
        quo_q <= '0;
      end
    end else begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      nlo_q <= {nlo_q[DIV_QW-2:0], 1'b0};
      quo_q <= {quo_q[DIV_QW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/plbc_front.sv */
// front end: buckets the pin levels and queues words for the back end
module plbc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plbc_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plbc_pkg::in_word_t in_data_i,
  output logic               q_valid_o,
  output plbc_pkg::item_t    q_item_o,
  input  logic               q_pop_i
);
  import plbc_pkg::*;

  localparam int QDEPTH = 2;

  logic [4:0][LVL_W-1:0] lvl;
  item_t                 item;
  item_t                 fifo_q [QDEPTH];
  logic                  wr_ptr_q;
  logic                  rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  full;
  logic                  push;
  logic                  pop;

  // bucket each pin: low first, then high, then mid
  always_comb begin
    lvl = {in_data_i.p5_level, in_data_i.p4_level, in_data_i.p3_level,
           in_data_i.p2_level, in_data_i.p1_level};
    item.func     = in_data_i.func;
    item.p1_level = in_data_i.p1_level;
    for (int i = 0; i < 5; i++) begin
      if (lvl[i] < cfg_i.low_level) begin
        item.sig[i] = BKT_LOW;
      end else if (lvl[i] > cfg_i.high_level) begin
        item.sig[i] = BKT_HIGH;
      end else if (lvl[i] >= cfg_i.mid_floor && lvl[i] <= cfg_i.mid_ceiling) begin
        item.sig[i] = BKT_MID;
      end else begin
        item.sig[i] = BKT_OTHER;
      end
    end
  end

  // two entry queue
  assign full       = cnt_q == 2'(QDEPTH);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

/* rtl/plbc_back.sv */
// back end: bin ring updates, evaluation sequencer and result register
module plbc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plbc_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  plbc_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plbc_pkg::out_word_t out_data_o
);
  import plbc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SMP_WR, ST_EV_RD, ST_EV_DATA, ST_EV_MDIV, ST_EV_CHK,
    ST_EV_LPW, ST_EV_SPW, ST_P2_RD, ST_P2_DATA, ST_F1, ST_F2, ST_F3,
    ST_F4, ST_F5, ST_BLW, ST_CLS, ST_RESP
  } st_e;

  st_e st_q, st_d;
  item_t item_q;

  logic [BIN_AW-1:0] ptr_q;
  logic [BINS-1:0]   clean_q;
  logic              clean_rd_q;

  logic              bram_we;
  logic [BIN_AW-1:0] bram_raddr;
  logic [BIN_W-1:0]  bram_rdata;
  bin_t              bin_rd;
  bin_t              bin_upd;

  logic              mram_we;
  logic [MEAN_W-1:0] mram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [BIN_AW-1:0] k_q;
  logic [C_W-1:0]    c_q;
  logic [TOT_W-1:0]  tot_q, lg_q, sm_q;
  logic [MEAN_W-1:0] mn_q, mx_q;
  logic [BIN_AW-1:0] t_q;
  logic [C_W-1:0]    h_q;
  logic              prev_q;
  logic [DIV_QW-1:0] lp_q, sp_q, bl_q;
  logic [C_W-1:0]    e_q, ts_q;
  logic [10:0]       as_q;
  logic [12:0]       dsn_q;
  logic [10:0]       dsd_q;
  logic [25:0]       pa_q;
  logic [16:0]       da_q;
  logic [31:0]       pb_q;
  logic [27:0]       db_q;
  logic [43:0]       pn_q;

  logic [1:0]        held_cls_q;
  logic [Q_W-1:0]    held_lp_q, held_sp_q, held_bl_q, held_cf_q;
  logic              out_valid_q;
  out_word_t         out_q;

  logic [MEAN_W-1:0] swing, sw16, sw_excess;
  logic [MEAN_W:0]   thr;
  logic              hi;
  logic              large_hit, small_hit, is_sample;
  logic [C_W-1:0]    e_w;
  logic [C_W:0]      t4, dd;
  logic [12:0]       h100, c70;
  logic [11:0]       c12, c48;
  logic [10:0]       c22;
  logic [DIV_QW-1:0] lim_l, lim_s, lim_b;
  logic [DIV_QW:0]   conf_sum;
  logic [1:0]        cls_w;
  logic [DIV_QW-1:0] conf_w;

  // bin and mean storage
  plbc_ram #(.WIDTH(BIN_W), .DEPTH(BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .waddr_i (ptr_q),
    .wdata_i (bin_upd),
    .raddr_i (bram_raddr),
    .rdata_o (bram_rdata)
  );

  plbc_ram #(.WIDTH(MEAN_W), .DEPTH(BINS)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mram_we),
    .waddr_i (c_q[BIN_AW-1:0]),
    .wdata_i (div_rsp.quo[MEAN_W-1:0]),
    .raddr_i (k_q),
    .rdata_o (mram_rdata)
  );

  plbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // bin read data, a cleared bin reads as empty
  assign bin_rd = clean_rd_q ? '0 : bin_t'(bram_rdata);

  // sample update and pattern match
  always_comb begin
    is_sample = item_q.func == FN_SAMPLE;
    large_hit = item_q.sig[0] == BKT_LOW && item_q.sig[1] == BKT_HIGH &&
                item_q.sig[2] == BKT_HIGH && item_q.sig[3] == BKT_HIGH &&
                item_q.sig[4] == BKT_HIGH;
    small_hit = item_q.sig[0] == BKT_MID && item_q.sig[1] == BKT_HIGH &&
                item_q.sig[2] == BKT_MID && item_q.sig[3] == BKT_HIGH &&
                item_q.sig[4] == BKT_HIGH;
    bin_upd.samples    = bin_rd.samples + 1'b1;
    bin_upd.large_hits = bin_rd.large_hits + CNT_W'(large_hit);
    bin_upd.small_hits = bin_rd.small_hits + CNT_W'(small_hit);
    bin_upd.p1_sum     = bin_rd.p1_sum + SUM_W'(item_q.p1_level);
  end

  // swing, high threshold and duty terms
  always_comb begin
    swing     = mx_q - mn_q;
    sw16      = {cfg_i.min_swing, 4'b0};
    sw_excess = swing - sw16;
    thr       = {1'b0, mn_q} + {1'b0, mn_q} + {1'b0, swing};
    hi        = {mram_rdata, 1'b0} >= thr;
    e_w       = (c_q > C_W'(8)) ? c_q : C_W'(8);
    t4        = {1'b0, t_q, 1'b0} + {1'b0, t_q, 1'b0};
    dd        = (t4 > {1'b0, e_w}) ? t4 - {1'b0, e_w} : {1'b0, e_w} - t4;
    h100      = 13'(h_q) * 13'd100;
    c12       = 12'(c_q) * 12'd12;
    c48       = 12'(c_q) * 12'd48;
    c70       = 13'(c_q) * 13'd70;
    c22       = 11'(c_q) * 11'd22;
  end

  // classification
  always_comb begin
    lim_l    = DIV_QW'({cfg_i.large_pct_limit, 8'b0});
    lim_s    = DIV_QW'({cfg_i.small_pct_limit, 8'b0});
    lim_b    = DIV_QW'({cfg_i.blink_limit, 8'b0});
    conf_sum = ({1'b0, sp_q} + {1'b0, bl_q}) >> 1;
    if (lp_q > lim_l && bl_q < lim_b) begin
      cls_w  = CLS_LARGE;
      conf_w = lp_q;
    end else if (sp_q > lim_s) begin
      if (bl_q >= lim_b) begin
        cls_w  = CLS_STANDBY;
        conf_w = (conf_sum > (DIV_QW+1)'(Q_ONE)) ? DIV_QW'(Q_ONE) : conf_sum[DIV_QW-1:0];
      end else begin
        cls_w  = CLS_SMALL;
        conf_w = sp_q;
      end
    end else begin
      cls_w  = CLS_UNKNOWN;
      conf_w = (lp_q > sp_q) ? lp_q : sp_q;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          case (q_item_i.func)
            FN_SAMPLE: st_d = ST_SMP_WR;
            FN_EVAL:   st_d = ST_EV_RD;
            default:   st_d = ST_RESP;
          endcase
        end
      end
      ST_SMP_WR:  st_d = ST_RESP;
      ST_EV_RD:   st_d = ST_EV_DATA;
      ST_EV_DATA: begin
        if (bin_rd.samples != '0) begin
          st_d = ST_EV_MDIV;
        end else if (k_q == BIN_AW'(BINS - 1)) begin
          st_d = ST_EV_CHK;
        end else begin
          st_d = ST_EV_RD;
        end
      end
      ST_EV_MDIV: begin
        if (!div_rsp.busy) begin
          st_d = (k_q == BIN_AW'(BINS - 1)) ? ST_EV_CHK : ST_EV_RD;
        end
      end
      ST_EV_CHK:  st_d = (tot_q == '0) ? ST_RESP : ST_EV_LPW;
      ST_EV_LPW:  if (!div_rsp.busy) st_d = ST_EV_SPW;
      ST_EV_SPW: begin
        if (!div_rsp.busy) begin
          if (c_q < C_W'(MIN_BINS) || swing < sw16) begin
            st_d = ST_CLS;
          end else begin
            st_d = ST_P2_RD;
          end
        end
      end
      ST_P2_RD:   st_d = ST_P2_DATA;
      ST_P2_DATA: st_d = ({1'b0, k_q} + 1'b1 == c_q) ? ST_F1 : ST_P2_RD;
      ST_F1:      st_d = ST_F2;
      ST_F2:      st_d = ST_F3;
      ST_F3:      st_d = ST_F4;
      ST_F4:      st_d = ST_F5;
      ST_F5:      st_d = ST_BLW;
      ST_BLW:     if (!div_rsp.busy) st_d = ST_CLS;
      ST_CLS:     st_d = ST_RESP;
      ST_RESP:    st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o       = 1'b0;
    bram_we       = 1'b0;
    bram_raddr    = ptr_q;
    mram_we       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'({bin_rd.p1_sum, 4'b0});
    div_req.den   = DIV_DW'(bin_rd.samples);
    case (st_q)
      ST_IDLE:    q_pop_o = q_valid_i && !out_valid_q;
      ST_SMP_WR:  bram_we = bin_rd.samples != CNT_MAX;
      ST_EV_RD:   bram_raddr = ptr_q + k_q + BIN_AW'(1);
      ST_EV_DATA: div_req.start = bin_rd.samples != '0;
      ST_EV_MDIV: mram_we = !div_rsp.busy;
      ST_EV_CHK: begin
        div_req.start = tot_q != '0;
        div_req.num   = DIV_NW'(lg_q) * DIV_NW'(Q_ONE);
        div_req.den   = DIV_DW'(tot_q);
      end
      ST_EV_LPW: begin
        div_req.start = !div_rsp.busy;
        div_req.num   = DIV_NW'(sm_q) * DIV_NW'(Q_ONE);
        div_req.den   = DIV_DW'(tot_q);
      end
      ST_F5: begin
        div_req.start = 1'b1;
        div_req.num   = pn_q;
        div_req.den   = db_q;
      end
      default: ;
    endcase
  end

  // control state: pointer, cleared bins, held result, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ptr_q       <= '0;
      clean_q     <= '1;
      held_cls_q  <= CLS_UNKNOWN;
      held_lp_q   <= '0;
      held_sp_q   <= '0;
      held_bl_q   <= '0;
      held_cf_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (q_pop_o && q_item_i.func == FN_TICK) begin
        ptr_q                         <= ptr_q + 1'b1;
        clean_q[ptr_q + BIN_AW'(1)]   <= 1'b1;
      end
      if (bram_we) begin
        clean_q[ptr_q] <= 1'b0;
      end
      if (st_q == ST_EV_CHK && tot_q == '0) begin
        held_cls_q <= CLS_UNKNOWN;
        held_lp_q  <= '0;
        held_sp_q  <= '0;
        held_bl_q  <= '0;
        held_cf_q  <= '0;
      end
      if (st_q == ST_CLS) begin
        held_cls_q <= cls_w;
        held_lp_q  <= lp_q[Q_W-1:0];
        held_sp_q  <= sp_q[Q_W-1:0];
        held_bl_q  <= bl_q[Q_W-1:0];
        held_cf_q  <= conf_w[Q_W-1:0];
      end
      if (st_q == ST_RESP) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // evaluation datapath
  always_ff @(posedge clk_i) begin
    clean_rd_q <= clean_q[bram_raddr];
    case (st_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          item_q <= q_item_i;
          k_q    <= '0;
          c_q    <= '0;
          tot_q  <= '0;
          lg_q   <= '0;
          sm_q   <= '0;
          t_q    <= '0;
          h_q    <= '0;
        end
      end
      ST_EV_DATA: begin
        if (bin_rd.samples != '0) begin
          tot_q <= tot_q + TOT_W'(bin_rd.samples);
          lg_q  <= lg_q + TOT_W'(bin_rd.large_hits);
          sm_q  <= sm_q + TOT_W'(bin_rd.small_hits);
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      ST_EV_MDIV: begin
        if (!div_rsp.busy) begin
          if (c_q == '0 || div_rsp.quo < mn_q) mn_q <= div_rsp.quo;
          if (c_q == '0 || div_rsp.quo > mx_q) mx_q <= div_rsp.quo;
          c_q <= c_q + 1'b1;
          k_q <= k_q + 1'b1;
        end
      end
      ST_EV_LPW: if (!div_rsp.busy) lp_q <= div_rsp.quo;
      ST_EV_SPW: begin
        if (!div_rsp.busy) begin
          sp_q <= div_rsp.quo;
          bl_q <= '0;
          k_q  <= '0;
        end
      end
      ST_P2_DATA: begin
        h_q    <= h_q + C_W'(hi);
        prev_q <= hi;
        if (k_q != '0 && hi != prev_q) t_q <= t_q + 1'b1;
        k_q    <= k_q + 1'b1;
      end
      ST_F1: begin
        e_q  <= e_w;
        ts_q <= (dd < {1'b0, e_w}) ? e_w - dd[C_W-1:0] : '0;
        as_q <= (sw_excess > MEAN_W'(SWING_RANGE)) ? 11'(SWING_RANGE)
                                                   : sw_excess[10:0];
        if (h100 >= 13'(c12) && h100 <= 13'(c48)) begin
          dsn_q <= 13'd1;
          dsd_q <= 11'd1;
        end else if (h100 < 13'(c12)) begin
          dsn_q <= h100;
          dsd_q <= c12[10:0];
        end else begin
          dsn_q <= (c70 > h100) ? c70 - h100 : '0;
          dsd_q <= c22;
        end
      end
      ST_F2: begin
        pa_q <= 26'(as_q) * 26'(Q_ONE);
        da_q <= 17'(e_q) * 17'(SWING_RANGE);
      end
      ST_F3: begin
        pb_q <= 32'(pa_q) * 32'(ts_q);
        db_q <= 28'(da_q) * 28'(dsd_q);
      end
      ST_F4:  pn_q <= 44'(pb_q) * 44'(dsn_q);
      ST_BLW: if (!div_rsp.busy) bl_q <= div_rsp.quo;
      ST_RESP: begin
        out_q.sig_p1      <= is_sample ? item_q.sig[0] : '0;
        out_q.sig_p2      <= is_sample ? item_q.sig[1] : '0;
        out_q.sig_p3      <= is_sample ? item_q.sig[2] : '0;
        out_q.sig_p4      <= is_sample ? item_q.sig[3] : '0;
        out_q.sig_p5      <= is_sample ? item_q.sig[4] : '0;
        out_q.panel_class <= held_cls_q;
        out_q.large_pct   <= held_lp_q;
        out_q.small_pct   <= held_sp_q;
        out_q.blink_score <= held_bl_q;
        out_q.confidence  <= held_cf_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/panel_level_blink_classifier.sv */
// top level: register file, front end and back end of the panel classifier
// the evaluate pass reads all 64 bins and divides each occupied bin for its
// mean, then runs the two percentage divisions and, with enough bins and swing,
// a blink pass over the occupied bins and a blink division; the shared serial
// divider sets the evaluate time. a two-word queue takes new words while a
// result waits. reset loads register defaults, marks every bin empty and holds
// class unknown; no clearing pass is run.
module panel_level_blink_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plbc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plbc_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i
);
  import plbc_pkg::*;

  cfg_t  cfg_q;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_level       <= RST_LOW_LEVEL;
      cfg_q.high_level      <= RST_HIGH_LEVEL;
      cfg_q.mid_floor       <= RST_MID_FLOOR;
      cfg_q.mid_ceiling     <= RST_MID_CEILING;
      cfg_q.large_pct_limit <= RST_LARGE_LIM;
      cfg_q.small_pct_limit <= RST_SMALL_LIM;
      cfg_q.blink_limit     <= RST_BLINK_LIM;
      cfg_q.min_swing       <= RST_MIN_SWING;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_LEVEL:   cfg_q.low_level       <= cfg_data_i[LVL_W-1:0];
        CFG_HIGH_LEVEL:  cfg_q.high_level      <= cfg_data_i[LVL_W-1:0];
        CFG_MID_FLOOR:   cfg_q.mid_floor       <= cfg_data_i[LVL_W-1:0];
        CFG_MID_CEILING: cfg_q.mid_ceiling     <= cfg_data_i[LVL_W-1:0];
        CFG_LARGE_LIM:   cfg_q.large_pct_limit <= cfg_data_i[LIM_W-1:0];
        CFG_SMALL_LIM:   cfg_q.small_pct_limit <= cfg_data_i[LIM_W-1:0];
        CFG_BLINK_LIM:   cfg_q.blink_limit     <= cfg_data_i[LIM_W-1:0];
        CFG_MIN_SWING:   cfg_q.min_swing       <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  plbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  plbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
